FILE: rtl/core/dfbb_pkg.sv
// Shared types and constants of the packet delay FIFO with byte budget.
// Used by the channel interfaces, the front, the back and the top level.
`default_nettype none

package dfbb_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TIME_BITS   = 48;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int HANDLE_W    = 32;
  localparam int BYTES_W     = 24;
  localparam int TOTAL_W     = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int OUT_CNT_W   = 7;

  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_ZERO_SIZE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY  = 1'b0,
    CFG_BUDGET = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_ZERO  = 3'd1,
    CMD_POP   = 3'd2,
    CMD_FLUSH = 3'd3,
    CMD_NOP   = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                    kind;
    logic [HANDLE_W-1:0]          handle;
    logic [BYTES_W-1:0]           bytes;
    logic signed [TIME_BITS-1:0]  time_us;
  } cmd_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]          handle;
    logic [BYTES_W-1:0]           bytes;
    logic signed [TIME_BITS-1:0]  time_us;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_t                      status;
    logic [HANDLE_W-1:0]          popped_handle;
    logic [BYTES_W-1:0]           popped_bytes;
    logic signed [TIME_BITS-1:0]  popped_time;
    logic [OUT_CNT_W-1:0]         flushed_count;
    logic [OUT_CNT_W-1:0]         dropped_count;
    logic [OUT_CNT_W-1:0]         queued_count;
    logic [TOTAL_W-1:0]           queued_bytes;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/dfbb_if.sv
// Valid/ready channel interfaces for request and result words.
// Depends on dfbb_pkg for field widths.
`default_nettype none

interface dfbb_in_if import dfbb_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic [REQ_W-1:0]             req_type;
  logic [HANDLE_W-1:0]          packet_handle;
  logic [BYTES_W-1:0]           packet_bytes;
  logic signed [TIME_BITS-1:0]  time_us;

  modport source (output valid, req_type, packet_handle, packet_bytes, time_us,
                  input ready);
  modport sink   (input valid, req_type, packet_handle, packet_bytes, time_us,
                  output ready);
endinterface

interface dfbb_out_if import dfbb_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic [STATUS_W-1:0]          status;
  logic [HANDLE_W-1:0]          popped_handle;
  logic [BYTES_W-1:0]           popped_bytes;
  logic signed [TIME_BITS-1:0]  popped_time;
  logic [OUT_CNT_W-1:0]         flushed_count;
  logic [OUT_CNT_W-1:0]         dropped_count;
  logic [OUT_CNT_W-1:0]         queued_count;
  logic [TOTAL_W-1:0]           queued_bytes;

  modport source (output valid, status, popped_handle, popped_bytes, popped_time,
                  flushed_count, dropped_count, queued_count, queued_bytes,
                  input ready);
  modport sink   (input valid, status, popped_handle, popped_bytes, popped_time,
                  flushed_count, dropped_count, queued_count, queued_bytes,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dfbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dfbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/dfbb_front.sv
// Front of the delay FIFO: accepts request words, classifies them and
// queues commands for the back. Depends on dfbb_pkg and dfbb_in_if.
`default_nettype none

module dfbb_front import dfbb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  dfbb_in_if.sink    in_ch,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  wire logic  cmd_ready
);

  cmd_t                  q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] fill_r, fill_nxt;
  cmd_t                  new_cmd;
  logic                  push, pop;

  function automatic logic [CMDQ_PTR_W-1:0] ptr_inc(input logic [CMDQ_PTR_W-1:0] p);
    return (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    new_cmd.handle  = in_ch.packet_handle;
    new_cmd.bytes   = in_ch.packet_bytes;
    new_cmd.time_us = in_ch.time_us;
    unique case (req_t'(in_ch.req_type))
      REQ_PUSH:  new_cmd.kind = (in_ch.packet_bytes == '0) ? CMD_ZERO : CMD_PUSH;
      REQ_POP:   new_cmd.kind = CMD_POP;
      REQ_FLUSH: new_cmd.kind = CMD_FLUSH;
      REQ_NOP:   new_cmd.kind = CMD_NOP;
      default:   new_cmd.kind = CMD_NOP;
    endcase
  end

  assign in_ch.ready = (fill_r != CMDQ_CNT_W'(CMDQ_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (fill_r != '0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dfbb_back.sv
// Back of the delay FIFO: runs queued commands against the entry RAM,
// drops oldest entries over budget and drives the result register.
// Depends on dfbb_pkg, dfbb_ram and dfbb_out_if.
`default_nettype none

module dfbb_back import dfbb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire cmd_t                  cmd,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  dfbb_out_if.source                 out_ch
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_DROP_RD = 4'b0010,
    S_POP_EX  = 4'b0100,
    S_DROP_EX = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [CNT_W-1:0]     dropped_r, dropped_nxt;
  logic [CFG_W-1:0]     delay_r;
  logic [TOTAL_W-1:0]   budget_r;
  cmd_t                 cmd_r;
  logic                 cmd_load;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 res_r, res_nxt;
  logic                 res_load;

  logic                 ram_we;
  entry_t               wr_entry;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               rd_entry;

  logic [TOTAL_W:0]     sum;
  logic [TIME_BITS:0]   age;
  logic                 age_ok;
  logic [TOTAL_W-1:0]   total_less;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic res_t make_res(input status_t st, input entry_t e, input logic take,
                                    input logic [CNT_W-1:0] flushed,
                                    input logic [CNT_W-1:0] dropped,
                                    input logic [CNT_W-1:0] cnt,
                                    input logic [TOTAL_W-1:0] tot);
    res_t r;
    r.status        = st;
    r.popped_handle = take ? e.handle  : '0;
    r.popped_bytes  = take ? e.bytes   : '0;
    r.popped_time   = take ? e.time_us : '0;
    r.flushed_count = OUT_CNT_W'(flushed);
    r.dropped_count = OUT_CNT_W'(dropped);
    r.queued_count  = OUT_CNT_W'(cnt);
    r.queued_bytes  = tot;
    return r;
  endfunction

  dfbb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (wr_entry),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign rd_entry         = entry_t'(ram_rdata);
  assign wr_entry.handle  = cmd.handle;
  assign wr_entry.bytes   = cmd.bytes;
  assign wr_entry.time_us = cmd.time_us;

  // Saturating add for the push, floored subtract for any removal.
  assign sum        = {1'b0, total_r} + (TOTAL_W + 1)'(cmd.bytes);
  assign total_less = (total_r >= TOTAL_W'(rd_entry.bytes)) ?
                      total_r - TOTAL_W'(rd_entry.bytes) : '0;

  // Age of the head: negative age is never ready.
  assign age    = {cmd_r.time_us[TIME_BITS-1], cmd_r.time_us}
                - {rd_entry.time_us[TIME_BITS-1], rd_entry.time_us};
  assign age_ok = !age[TIME_BITS] && (age >= (TIME_BITS + 1)'(delay_r));

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    dropped_nxt   = dropped_r;
    cmd_ready     = 1'b0;
    cmd_load      = 1'b0;
    ram_we        = 1'b0;
    res_load      = 1'b0;
    res_nxt       = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && (!out_valid_r || out_ch.ready)) begin
          cmd_ready   = 1'b1;
          cmd_load    = 1'b1;
          dropped_nxt = '0;
          unique case (cmd.kind)
            CMD_PUSH: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                res_load = 1'b1;
                res_nxt  = make_res(ST_FULL, rd_entry, 1'b0, '0, '0, count_r, total_r);
              end else begin
                ram_we    = 1'b1;
                tail_nxt  = idx_inc(tail_r);
                count_nxt = count_r + 1'b1;
                total_nxt = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                if (budget_r != '0) begin
                  state_nxt = S_DROP_RD;
                end else begin
                  res_load = 1'b1;
                  res_nxt  = make_res(ST_DONE, rd_entry, 1'b0, '0, '0,
                                      count_nxt, total_nxt);
                end
              end
            end
            CMD_ZERO: begin
              res_load = 1'b1;
              res_nxt  = make_res(ST_ZERO_SIZE, rd_entry, 1'b0, '0, '0, count_r, total_r);
            end
            CMD_POP: begin
              if (count_r == '0) begin
                res_load = 1'b1;
                res_nxt  = make_res(ST_NOT_READY, rd_entry, 1'b0, '0, '0,
                                    count_r, total_r);
              end else begin
                state_nxt = S_POP_EX;
              end
            end
            CMD_FLUSH: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
              total_nxt = '0;
              res_load  = 1'b1;
              res_nxt   = make_res(ST_DONE, rd_entry, 1'b0, count_r, '0, '0, '0);
            end
            CMD_NOP: begin
              res_load = 1'b1;
              res_nxt  = make_res(ST_DONE, rd_entry, 1'b0, '0, '0, count_r, total_r);
            end
            default: begin
              res_load = 1'b1;
              res_nxt  = make_res(ST_DONE, rd_entry, 1'b0, '0, '0, count_r, total_r);
            end
          endcase
        end
      end
      S_DROP_RD: begin
        // Head entry is read this cycle; drop it next cycle if still over.
        if ((count_r != '0) && (total_r > budget_r)) begin
          state_nxt = S_DROP_EX;
        end else begin
          state_nxt = S_IDLE;
          res_load  = 1'b1;
          res_nxt   = make_res(ST_DONE, rd_entry, 1'b0, '0, dropped_r, count_r, total_r);
        end
      end
      S_DROP_EX: begin
        head_nxt    = idx_inc(head_r);
        count_nxt   = count_r - 1'b1;
        total_nxt   = total_less;
        dropped_nxt = dropped_r + 1'b1;
        state_nxt   = S_DROP_RD;
      end
      S_POP_EX: begin
        state_nxt = S_IDLE;
        res_load  = 1'b1;
        if (age_ok) begin
          head_nxt  = idx_inc(head_r);
          count_nxt = count_r - 1'b1;
          total_nxt = total_less;
          res_nxt   = make_res(ST_DONE, rd_entry, 1'b1, '0, '0, count_nxt, total_nxt);
        end else begin
          res_nxt   = make_res(ST_NOT_READY, rd_entry, 1'b0, '0, '0, count_r, total_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      total_r     <= '0;
      dropped_r   <= '0;
      out_valid_r <= 1'b0;
      delay_r     <= '0;
      budget_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_DELAY:  delay_r  <= cfg_wdata;
          CFG_BUDGET: budget_r <= TOTAL_W'(cfg_wdata);
          default:    delay_r  <= delay_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_load) begin
      cmd_r <= cmd;
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = res_r.status;
  assign out_ch.popped_handle = res_r.popped_handle;
  assign out_ch.popped_bytes  = res_r.popped_bytes;
  assign out_ch.popped_time   = res_r.popped_time;
  assign out_ch.flushed_count = res_r.flushed_count;
  assign out_ch.dropped_count = res_r.dropped_count;
  assign out_ch.queued_count  = res_r.queued_count;
  assign out_ch.queued_bytes  = res_r.queued_bytes;

endmodule

`default_nettype wire

FILE: rtl/core/delay_fifo_byte_budget_top.sv
// Packet delay FIFO with byte budget and drop-oldest.
//
// in_ch carries request words (push, pop if aged, flush); out_ch returns one
// result word per request, in order. cfg_we/cfg_index/cfg_wdata write the
// delay (index 0) and the byte budget (index 1, zero means no limit); write
// them only while no request is in flight.
//
// Flush, reject, unused codes and pushes with no budget finish in the idle
// state; a pop takes one entry RAM read of the head; a push under a budget
// runs the drop loop, which reads one head entry and retires it on each pass
// while the total is over the budget and the queue is not empty.
// Throughput: up to one single-step request per cycle while out_ch is ready,
// set by the back sequencer; a two-word command queue links front and back.
//
// Reset empties the queue and clears both registers; entry RAM contents are
// not cleared. When out_ch stalls, the result register holds, the back stops
// taking commands and the command queue fills before in_ch.ready drops.
`default_nettype none

module delay_fifo_byte_budget_top import dfbb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  dfbb_in_if.sink                    in_ch,
  dfbb_out_if.source                 out_ch
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  dfbb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  dfbb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
